// File: rtl/core/tkf_pkg.sv
package tkf_pkg;

  typedef struct packed {
    logic               command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] angular_rate;
    logic [24:0]        time_step;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] bias_estimate;
    logic               dynamic_used;
  } out_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_B, ST_SSTART, ST_SQRT, ST_PREP, ST_DSTART, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_ANG, OP_T11, OP_P00, OP_P11,
    OP_K0Y, OP_K1Y, OP_K1P00, OP_K1P01, OP_K0P00, OP_K0P01
  } op_t;

  localparam logic [2:0] REG_ANGLE_NOISE = 3'd0;
  localparam logic [2:0] REG_BIAS_NOISE  = 3'd1;
  localparam logic [2:0] REG_STATIC_R    = 3'd2;
  localparam logic [2:0] REG_DYNAMIC_R   = 3'd3;
  localparam logic [2:0] REG_GRAVITY     = 3'd4;
  localparam logic [2:0] REG_THRESHOLD   = 3'd5;
  localparam logic [2:0] REG_START_BIAS  = 3'd6;

  localparam logic CMD_RESTART = 1'b1;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 56;
  localparam logic [24:0] ONE_SECOND = 25'h1000000;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tkf_iter.sv
module tkf_iter (
  input  logic              clk,
  input  logic              rst_n,
  input  tkf_pkg::iter_ctl_t ctl,
  input  logic [63:0]       radicand,
  input  logic [55:0]       numer,
  input  logic [33:0]       denom,
  output logic              done,
  output logic [55:0]       result
);
  import tkf_pkg::*;

  logic        run_r, done_r, sqrt_r;
  logic [5:0]  cnt_r;
  logic [63:0] src_r;
  logic [35:0] rem_r;
  logic [55:0] res_r;
  logic [33:0] den_r;
  logic [35:0] rem2, trial, diff;
  logic        take;

  // One root bit or one quotient bit is settled each cycle.
  always_comb begin
    if (sqrt_r) begin
      rem2  = {rem_r[33:0], src_r[63:62]};
      trial = {res_r[33:0], 2'b01};
    end else begin
      rem2  = {rem_r[34:0], src_r[63]};
      trial = {2'b00, den_r};
    end
    take = (rem2 >= trial);
    diff = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= ctl.is_sqrt ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sqrt_r <= ctl.is_sqrt;
      src_r  <= ctl.is_sqrt ? radicand : {numer, 8'd0};
      den_r  <= denom;
      rem_r  <= '0;
      res_r  <= '0;
    end else if (run_r) begin
      src_r <= sqrt_r ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
      rem_r <= take ? diff : rem2;
      res_r <= {res_r[54:0], take};
    end
  end

  assign done   = done_r;
  assign result = res_r;
endmodule

// File: rtl/core/tilt_kalman_filter.sv
// Sequence: a restart word clears the state and goes straight to ST_DONE; a filter word
// makes 13 passes through the shared multiplier, a 32-step square root and two 56-step
// gain divisions, the divisions being skipped when the innovation variance is zero.
// Throughput: one word at a time; the input is ready again once the result is registered.
// Reset (synchronous, active low) clears the angle, bias and covariance and loads the
// register defaults.
module tilt_kalman_filter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tkf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tkf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
  import tkf_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  in_t    in_r;
  out_t   out_data_r, out_data_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [31:0] qa_r, qb_r, ra_r, rb_r;
  logic [30:0] grav_r, thr_r;
  logic signed [31:0] sbias_r;

  logic signed [31:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [31:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic [24:0]        dt_r, dt_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic               dyn_r, dyn_nxt, div_sel_r, div_sel_nxt;
  logic signed [35:0] inner_r, inner_nxt;
  logic signed [31:0] y_r, y_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [34:0] s_r, s_nxt;

  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod_r, rsum;
  logic signed [47:0] rnd;
  logic signed [49:0] rnd50;

  iter_ctl_t   ictl;
  logic        it_done;
  logic [55:0] it_res;
  logic [31:0] num_mag;
  logic [33:0] den_mag;
  logic signed [31:0] num_sel;
  logic signed [34:0] s_abs;
  logic signed [31:0] kval;
  logic signed [33:0] dev;
  logic [33:0]        dev_abs;

  logic [31:0] abs_x, abs_y, abs_z;
  logic signed [32:0] rate;

  assign abs_x = in_r.accel_x[31] ? 32'(-in_r.accel_x) : in_r.accel_x;
  assign abs_y = in_r.accel_y[31] ? 32'(-in_r.accel_y) : in_r.accel_y;
  assign abs_z = in_r.accel_z[31] ? 32'(-in_r.accel_z) : in_r.accel_z;
  assign rate  = 33'(in_r.angular_rate) - 33'(bias_r);

  // Shared multiplier: product registered, rounded to nearest with ties upward.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_SQX:   begin mul_a = {4'd0, abs_x}; mul_b = {4'd0, abs_x}; end
      OP_SQY:   begin mul_a = {4'd0, abs_y}; mul_b = {4'd0, abs_y}; end
      OP_SQZ:   begin mul_a = {4'd0, abs_z}; mul_b = {4'd0, abs_z}; end
      OP_ANG:   begin mul_a = {11'd0, dt_r}; mul_b = 36'(rate); end
      OP_T11:   begin mul_a = {11'd0, dt_r}; mul_b = 36'(p11_r); end
      OP_P00:   begin mul_a = {11'd0, dt_r}; mul_b = inner_r; end
      OP_P11:   begin mul_a = {4'd0, qb_r};  mul_b = {11'd0, dt_r}; end
      OP_K0Y:   begin mul_a = 36'(k0_r); mul_b = 36'(y_r); end
      OP_K1Y:   begin mul_a = 36'(k1_r); mul_b = 36'(y_r); end
      OP_K1P00: begin mul_a = 36'(k1_r); mul_b = 36'(p00_r); end
      OP_K1P01: begin mul_a = 36'(k1_r); mul_b = 36'(p01_r); end
      OP_K0P00: begin mul_a = 36'(k0_r); mul_b = 36'(p00_r); end
      OP_K0P01: begin mul_a = 36'(k0_r); mul_b = 36'(p01_r); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rsum  = prod_r + 72'sd8388608;
  assign rnd   = $signed(rsum[71:24]);
  assign rnd50 = 50'(rnd);

  // Gain divider operands and the signed, saturated quotient.
  assign num_sel = div_sel_r ? p10_r : p00_r;
  assign num_mag = num_sel[31] ? 32'(-num_sel) : num_sel;
  assign s_abs   = s_r[34] ? -s_r : s_r;
  assign den_mag = s_abs[33:0];

  always_comb begin
    if (num_sel[31] ^ s_r[34]) begin
      if (it_res > 56'h80000000) kval = 32'sh80000000;
      else                       kval = -$signed(it_res[31:0]);
    end else begin
      if (it_res > 56'h7FFFFFFF) kval = 32'sh7FFFFFFF;
      else                       kval = $signed(it_res[31:0]);
    end
  end

  assign dev     = $signed({2'b00, it_res[31:0]}) - $signed({3'b000, grav_r});
  assign dev_abs = dev[33] ? 34'(-dev) : dev;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ang_nxt  = ang_r;   bias_nxt = bias_r;
    p00_nxt  = p00_r;   p01_nxt  = p01_r;   p10_nxt = p10_r;   p11_nxt = p11_r;
    dt_nxt   = dt_r;    acc_nxt  = acc_r;   dyn_nxt = dyn_r;
    inner_nxt = inner_r; y_nxt = y_r; s_nxt = s_r; k0_nxt = k0_r; k1_nxt = k1_r;
    div_sel_nxt = div_sel_r;
    ictl.start   = 1'b0;
    ictl.is_sqrt = 1'b0;
    in_ready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.command == CMD_RESTART) begin
            ang_nxt  = '0;
            bias_nxt = sbias_r;
            p00_nxt  = '0; p01_nxt = '0; p10_nxt = '0; p11_nxt = '0;
            dyn_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            dt_nxt    = (in_data.time_step > ONE_SECOND) ? ONE_SECOND : in_data.time_step;
            op_nxt    = OP_SQX;
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: begin
        state_nxt = ST_MUL_A;
        case (op_r)
          OP_SQX: begin acc_nxt = prod_r[63:0]; op_nxt = OP_SQY; end
          OP_SQY: begin acc_nxt = acc_r + prod_r[63:0]; op_nxt = OP_SQZ; end
          OP_SQZ: begin acc_nxt = acc_r + prod_r[63:0]; state_nxt = ST_SSTART; end
          OP_ANG: begin ang_nxt = sat32(50'(ang_r) + rnd50); op_nxt = OP_T11; end
          OP_T11: begin
            // The old off-diagonal terms feed the angle-variance term first.
            inner_nxt = 36'(rnd) - 36'(p01_r) - 36'(p10_r) + $signed({4'd0, qa_r});
            p01_nxt   = sat32(50'(p01_r) - rnd50);
            p10_nxt   = sat32(50'(p10_r) - rnd50);
            op_nxt    = OP_P00;
          end
          OP_P00: begin p00_nxt = sat32(50'(p00_r) + rnd50); op_nxt = OP_P11; end
          OP_P11: begin p11_nxt = sat32(50'(p11_r) + rnd50); state_nxt = ST_PREP; end
          OP_K0Y: begin ang_nxt = sat32(50'(ang_r) + rnd50); op_nxt = OP_K1Y; end
          OP_K1Y: begin bias_nxt = sat32(50'(bias_r) + rnd50); op_nxt = OP_K1P00; end
          // Rows are updated in an order that reads each old entry before it changes.
          OP_K1P00: begin p10_nxt = sat32(50'(p10_r) - rnd50); op_nxt = OP_K1P01; end
          OP_K1P01: begin p11_nxt = sat32(50'(p11_r) - rnd50); op_nxt = OP_K0P00; end
          OP_K0P00: begin p00_nxt = sat32(50'(p00_r) - rnd50); op_nxt = OP_K0P01; end
          OP_K0P01: begin p01_nxt = sat32(50'(p01_r) - rnd50); state_nxt = ST_DONE; end
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SSTART: begin
        ictl.start   = 1'b1;
        ictl.is_sqrt = 1'b1;
        state_nxt    = ST_SQRT;
      end
      ST_SQRT: begin
        if (it_done) begin
          dyn_nxt   = (dev_abs > {3'b000, thr_r});
          op_nxt    = OP_ANG;
          state_nxt = ST_MUL_A;
        end
      end
      ST_PREP: begin
        y_nxt       = sat32(50'(in_r.measured_angle) - 50'(ang_r));
        s_nxt       = 35'(p00_r) + $signed({3'd0, dyn_r ? rb_r : ra_r});
        div_sel_nxt = 1'b0;
        state_nxt   = ST_DSTART;
      end
      ST_DSTART: begin
        if (s_r == '0) begin
          k0_nxt    = '0;
          k1_nxt    = '0;
          op_nxt    = OP_K0Y;
          state_nxt = ST_MUL_A;
        end else begin
          ictl.start = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (it_done) begin
          if (!div_sel_r) begin
            k0_nxt      = kval;
            div_sel_nxt = 1'b1;
            state_nxt   = ST_DSTART;
          end else begin
            k1_nxt    = kval;
            op_nxt    = OP_K0Y;
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.filtered_angle = ang_r;
          out_data_nxt.bias_estimate  = bias_r;
          out_data_nxt.dynamic_used   = dyn_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  tkf_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ictl),
    .radicand (acc_r),
    .numer    ({num_mag, 24'd0}),
    .denom    (den_mag),
    .done     (it_done),
    .result   (it_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ang_r  <= '0;  bias_r <= '0;
      p00_r  <= '0;  p01_r  <= '0;  p10_r <= '0;  p11_r <= '0;
      qa_r   <= 32'd16777;
      qb_r   <= 32'd50332;
      ra_r   <= 32'd503316;
      rb_r   <= 32'd5033165;
      grav_r <= 31'd642690;
      thr_r  <= 31'd131072;
      sbias_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r  <= ang_nxt;  bias_r <= bias_nxt;
      p00_r  <= p00_nxt;  p01_r  <= p01_nxt;  p10_r <= p10_nxt;  p11_r <= p11_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_NOISE: qa_r    <= cfg_wdata;
          REG_BIAS_NOISE:  qb_r    <= cfg_wdata;
          REG_STATIC_R:    ra_r    <= cfg_wdata;
          REG_DYNAMIC_R:   rb_r    <= cfg_wdata;
          REG_GRAVITY:     grav_r  <= cfg_wdata[30:0];
          REG_THRESHOLD:   thr_r   <= cfg_wdata[30:0];
          REG_START_BIAS:  sbias_r <= cfg_wdata;
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= mul_a * mul_b;
    dt_r       <= dt_nxt;
    acc_r      <= acc_nxt;
    dyn_r      <= dyn_nxt;
    inner_r    <= inner_nxt;
    y_r        <= y_nxt;
    s_r        <= s_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    div_sel_r  <= div_sel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

// File: tb/tilt_kalman_filter_tb.sv
module tilt_kalman_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkf_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam longint unsigned ONE_SEC_Q24 = 64'd1 << 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  tilt_kalman_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter state mirrored in the testbench.
  longint unsigned tilt_regs[7];
  longint          est_angle;
  longint          est_bias;
  longint          est_cov[4];

  out_t    pending_angles[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      burst_left = 0;
  int      hold_request = 0;
  int      hold_cnt = 0;
  int      ready_mode = 0;
  int      mode_cnt = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift gives floor, so this rounds to nearest with ties upward.
  function automatic longint q24_product(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< 23);
    return p >>> 24;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned squared_mag(logic signed [31:0] f);
    longint v;
    longint unsigned u;
    v = longint'(f);
    u = (v < 0) ? -v : v;
    return u * u;
  endfunction

  function automatic void reset_model();
    tilt_regs = '{64'd16777, 64'd50332, 64'd503316, 64'd5033165, 64'd642690,
                  64'd131072, 64'd0};
    est_angle = 0;
    est_bias = 0;
    foreach (est_cov[i]) est_cov[i] = 0;
  endfunction

  function automatic out_t filter_angle(in_t w);
    out_t    res;
    longint  dt, rate, p00, p01, p10, p11, inner, innov, s, k0, k1, dev, r;
    longint unsigned mag;
    logic    dyn;
    res = '0;
    if (w.command == CMD_RESTART) begin
      est_angle = 0;
      est_bias = longint'($signed(tilt_regs[REG_START_BIAS][31:0]));
      foreach (est_cov[i]) est_cov[i] = 0;
      res.bias_estimate = est_bias[31:0];
      return res;
    end
    mag = int_sqrt(squared_mag(w.accel_x) + squared_mag(w.accel_y) +
                   squared_mag(w.accel_z));
    dev = longint'(mag) - longint'(tilt_regs[REG_GRAVITY]);
    if (dev < 0) dev = -dev;
    dyn = dev > longint'(tilt_regs[REG_THRESHOLD]);
    r = longint'(dyn ? tilt_regs[REG_DYNAMIC_R] : tilt_regs[REG_STATIC_R]);

    dt = longint'(w.time_step);
    if (dt > longint'(ONE_SEC_Q24)) dt = longint'(ONE_SEC_Q24);
    rate = longint'(w.angular_rate) - est_bias;
    est_angle = clamp32(est_angle + q24_product(dt, rate));

    p00 = est_cov[0];
    p01 = est_cov[1];
    p10 = est_cov[2];
    p11 = est_cov[3];
    inner = q24_product(dt, p11) - p01 - p10 + longint'(tilt_regs[REG_ANGLE_NOISE]);
    p00 = clamp32(p00 + q24_product(dt, inner));
    p01 = clamp32(p01 - q24_product(dt, p11));
    p10 = clamp32(p10 - q24_product(dt, p11));
    p11 = clamp32(p11 + q24_product(longint'(tilt_regs[REG_BIAS_NOISE]), dt));

    innov = clamp32(longint'(w.measured_angle) - est_angle);
    s = p00 + r;
    if (s == 0) begin
      k0 = 0;
      k1 = 0;
    end else begin
      k0 = clamp32((p00 * longint'(ONE_SEC_Q24)) / s);
      k1 = clamp32((p10 * longint'(ONE_SEC_Q24)) / s);
    end
    est_angle = clamp32(est_angle + q24_product(k0, innov));
    est_bias = clamp32(est_bias + q24_product(k1, innov));

    est_cov[0] = clamp32(p00 - q24_product(k0, p00));
    est_cov[1] = clamp32(p01 - q24_product(k0, p01));
    est_cov[2] = clamp32(p10 - q24_product(k1, p00));
    est_cov[3] = clamp32(p11 - q24_product(k1, p01));

    res.filtered_angle = est_angle[31:0];
    res.bias_estimate = est_bias[31:0];
    res.dynamic_used = dyn;
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_sample(in_t w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_angles.push_back(filter_angle(w));
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    longint unsigned mask;
    mask = (idx == REG_GRAVITY || idx == REG_THRESHOLD) ? 64'h7FFFFFFF : 64'hFFFFFFFF;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tilt_regs[idx] = longint'(val) & mask;
    @(negedge clk);
  endtask

  function automatic in_t filter_word(logic signed [31:0] ang, logic signed [31:0] rate,
                                      logic [24:0] dt, logic signed [31:0] ax,
                                      logic signed [31:0] ay, logic signed [31:0] az);
    in_t w;
    w = '0;
    w.measured_angle = ang;
    w.angular_rate = rate;
    w.time_step = dt;
    w.accel_x = ax;
    w.accel_y = ay;
    w.accel_z = az;
    return w;
  endfunction

  function automatic in_t restart_word();
    in_t w;
    w = '0;
    w.command = CMD_RESTART;
    return w;
  endfunction

  // Mostly plausible IMU data near gravity, with a share of unrestricted words and restarts.
  function automatic in_t random_word();
    in_t w;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return restart_word();
    if (pick < 20) begin
      w = '0;
      w.measured_angle = $urandom;
      w.angular_rate = $urandom;
      w.time_step = 25'($urandom);
      w.accel_x = $urandom;
      w.accel_y = $urandom;
      w.accel_z = $urandom;
      return w;
    end
    w = filter_word($signed($urandom_range(0, 12000000)) - 32'sd6000000,
                    $signed($urandom_range(0, 4000000)) - 32'sd2000000,
                    25'($urandom_range(0, 1 << 21)),
                    $signed($urandom_range(0, 400000)) - 32'sd200000,
                    $signed($urandom_range(0, 400000)) - 32'sd200000,
                    32'sd642690 + $signed($urandom_range(0, 400000)) - 32'sd200000);
    return w;
  endfunction

  task automatic test_restart();
    write_reg(REG_START_BIAS, 32'h7FFFFFFF);
    send_sample(restart_word());
    send_sample(filter_word(32'sd65536, 32'sd0, 25'd16777, 0, 0, 32'sd642690));
    wait_drained();
    write_reg(REG_START_BIAS, 32'h80000000);
    send_sample(restart_word());
    send_sample(filter_word(32'sd0, 32'sd0, 25'd16777, 0, 0, 32'sd642690));
  endtask

  task automatic test_field_extremes();
    send_sample(filter_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 25'h1000000,
                            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_sample(filter_word(32'sh80000000, 32'sh80000000, 25'h1FFFFFF,
                            32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_sample(filter_word(32'sh7FFFFFFF, 32'sh80000000, 25'd0, 0, 0, 0));
    send_sample(filter_word(32'sh80000000, 32'sh7FFFFFFF, 25'h1000001,
                            32'sh7FFFFFFF, 0, 32'sh80000000));
    send_sample(filter_word(32'sd0, 32'sd0, 25'h0FFFFFF, 0, 32'sd642690, 0));
    send_sample(restart_word());
    send_sample(filter_word(32'sh80000000, 32'sh7FFFFFFF, 25'h1000000, 0, 0, 32'sd642690));
  endtask

  // With no angle process noise, zero static noise and a zero time step the
  // innovation variance is zero straight after a restart.
  task automatic test_zero_innovation();
    wait_drained();
    write_reg(REG_ANGLE_NOISE, 32'd0);
    write_reg(REG_STATIC_R, 32'd0);
    write_reg(REG_GRAVITY, 32'd642690);
    write_reg(REG_THRESHOLD, 32'd0);
    send_sample(restart_word());
    send_sample(filter_word(32'sd123456, 32'sd5000, 25'd0, 0, 0, 32'sd642690));
    send_sample(filter_word(32'sd123456, 32'sd5000, 25'd0, 0, 0, 32'sd642691));
  endtask

  task automatic test_config_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      for (int idx = 0; idx < 7; idx++) begin
        case (phase)
          0: write_reg(idx[2:0], 32'd0);
          1: write_reg(idx[2:0], 32'hFFFFFFFF);
          default: write_reg(idx[2:0], (idx == REG_GRAVITY) ? $urandom_range(0, 1500000)
                                      : (idx == REG_THRESHOLD) ? $urandom_range(0, 400000)
                                      : $urandom);
        endcase
      end
      send_sample(restart_word());
      repeat (30) send_sample(random_word());
    end
    wait_drained();
    write_reg(REG_ANGLE_NOISE, 32'd16777);
    write_reg(REG_BIAS_NOISE, 32'd50332);
    write_reg(REG_STATIC_R, 32'd503316);
    write_reg(REG_DYNAMIC_R, 32'd5033165);
    write_reg(REG_GRAVITY, 32'd642690);
    write_reg(REG_THRESHOLD, 32'd131072);
    write_reg(REG_START_BIAS, $urandom_range(0, 200000));
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_request = 3000;
    burst_left = 10;
    repeat (6) send_sample(random_word());
  endtask

  task automatic test_random_stream();
    send_sample(restart_word());
    repeat (420) send_sample(random_word());
  endtask

  // Outside a requested hold, the receiver pattern changes every so often: always ready, mostly ready
  // or mostly stalled.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_cnt = hold_request;
      hold_request = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(20, 300);
      end
      mode_cnt--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each result word is compared with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result word with nothing expected, got %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (out_data.filtered_angle !== want.filtered_angle) begin
          $display("%0t: filtered_angle expected %0d got %0d", $time,
                   want.filtered_angle, out_data.filtered_angle);
          error_count++;
        end
        if (out_data.bias_estimate !== want.bias_estimate) begin
          $display("%0t: bias_estimate expected %0d got %0d", $time,
                   want.bias_estimate, out_data.bias_estimate);
          error_count++;
        end
        if (out_data.dynamic_used !== want.dynamic_used) begin
          $display("%0t: dynamic_used expected %0b got %0b", $time,
                   want.dynamic_used, out_data.dynamic_used);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_restart();
    test_field_extremes();
    test_zero_innovation();
    test_config_sweep();
    test_backpressure();
    test_random_stream();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tkf_pkg.sv
rtl/core/tkf_iter.sv
rtl/core/tilt_kalman_filter.sv
tb/tilt_kalman_filter_tb.sv
